@@ rtl/bayes_cpt_probability_combiner_macros.svh @@
// ----------------------------------------------------------------------------
// Bayes CPT combiner assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BAYES_CPT_PROBABILITY_COMBINER_MACROS_SVH
`define BAYES_CPT_PROBABILITY_COMBINER_MACROS_SVH

`ifndef SYNTHESIS

`define BCPC_ASSERT_IMP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define BCPC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`else

`define BCPC_ASSERT_IMP(label, clk, rst, prop, msg)

`define BCPC_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/bcpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bcpc_pkg
// Shared types, widths and helpers of the Bayes CPT probability combiner.
// ----------------------------------------------------------------------------
`default_nettype none

package bcpc_pkg;

   localparam int PROB_W      = 8;
   localparam int PCT_W       = 7;
   localparam int ENTRY_W     = 8;
   localparam int PAIR_W      = 14;
   localparam int KSUM_W      = 22;
   localparam int KQ_W        = 8;
   localparam int MSUM_W      = 14;
   localparam int TABLE_MAX   = 32;
   localparam int TABLE_WORDS = 4;
   localparam int KERNELS     = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int PCOUNT_W    = 3;

   localparam logic [PCOUNT_W-1:0] RESET_PARENT_COUNT = 3'd5;

   typedef logic [PCT_W-1:0] pct_type;
   typedef logic [TABLE_MAX-1:0][ENTRY_W-1:0] table_type;
   typedef logic [TABLE_WORDS-1:0][CSR_DATA_W-1:0] table_words_type;

   typedef enum logic [1:0] {
      PARENTS_2,
      PARENTS_3,
      PARENTS_4,
      PARENTS_5
   } parents_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PARENT_COUNT = 3'd0,
      CSR_TABLE_0      = 3'd1,
      CSR_TABLE_1      = 3'd2,
      CSR_TABLE_2      = 3'd3,
      CSR_TABLE_3      = 3'd4
   } csr_index_type;

   typedef struct packed {
      pct_type     prob_a;
      pct_type     prob_b;
      pct_type     prob_c;
      pct_type     prob_d;
      pct_type     prob_e;
      parents_type parents;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic pct_type clamp_pct(input logic [PROB_W-1:0] v, input pct_type full);
      clamp_pct = (v > PROB_W'(full)) ? full : v[PCT_W-1:0];
   endfunction

   function automatic logic [MSUM_W-1:0] mix_sum(input pct_type lo, input pct_type hi,
                                                 input pct_type p, input pct_type full);
      mix_sum = MSUM_W'(lo) * MSUM_W'(full - p) + MSUM_W'(hi) * MSUM_W'(p)
              + MSUM_W'(full >> 1);
   endfunction

endpackage

`default_nettype wire

@@ rtl/bcpc_if.sv @@
// ----------------------------------------------------------------------------
// bcpc channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bcpc_req_if
   import bcpc_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [PROB_W-1:0] prob_a;
   logic [PROB_W-1:0] prob_b;
   logic [PROB_W-1:0] prob_c;
   logic [PROB_W-1:0] prob_d;
   logic [PROB_W-1:0] prob_e;

   modport source (output valid, prob_a, prob_b, prob_c, prob_d, prob_e, input ready);
   modport sink (input valid, prob_a, prob_b, prob_c, prob_d, prob_e, output ready);
endinterface

interface bcpc_rsp_if
   import bcpc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [PCT_W-1:0] child_prob;

   modport source (output valid, child_prob, input ready);
   modport sink (input valid, child_prob, output ready);
endinterface

interface bcpc_csr_if
   import bcpc_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/bcpc_front.sv @@
// ----------------------------------------------------------------------------
// bcpc_front
// Accepts request items, clamps probabilities, classifies the parent count.
// ----------------------------------------------------------------------------
`default_nettype none

module bcpc_front
   import bcpc_pkg::*;
#(
   parameter int PERCENT_FULL = 100
) (
   input  wire logic                clock,
   input  wire logic                reset,
   bcpc_req_if.sink                 req_if,
   input  wire logic [PCOUNT_W-1:0] parent_count,
   input  wire qstat_type           qstat,
   output logic                     push,
   output work_type                 work
);

   localparam pct_type FULL = pct_type'(PERCENT_FULL);

   logic     front_valid_ff, front_valid_in;
   work_type work_ff, work_in;
   work_type classified;
   logic     accept;

   assign push          = front_valid_ff && !qstat.full;
   assign req_if.ready  = !front_valid_ff || !qstat.full;
   assign accept        = req_if.valid && req_if.ready;
   assign work          = work_ff;

   always_comb begin
      classified.prob_a = clamp_pct(req_if.prob_a, FULL);
      classified.prob_b = clamp_pct(req_if.prob_b, FULL);
      classified.prob_c = clamp_pct(req_if.prob_c, FULL);
      classified.prob_d = clamp_pct(req_if.prob_d, FULL);
      classified.prob_e = clamp_pct(req_if.prob_e, FULL);
      if (parent_count inside {[3'd0:3'd2]}) begin
         classified.parents = PARENTS_2;
      end else if (parent_count == 3'd3) begin
         classified.parents = PARENTS_3;
      end else if (parent_count == 3'd4) begin
         classified.parents = PARENTS_4;
      end else begin
         classified.parents = PARENTS_5;
      end
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      work_in        = work_ff;
      if (accept) begin
         front_valid_in = 1'b1;
         work_in        = classified;
      end else if (push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

endmodule

`default_nettype wire

@@ rtl/bcpc_queue.sv @@
// ----------------------------------------------------------------------------
// bcpc_queue
// Short item queue between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bayes_cpt_probability_combiner_macros.svh"

module bcpc_queue
   import bcpc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   input  wire logic     pop,
   output work_type      pop_data,
   output qstat_type     qstat
);

   work_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign pop_data    = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `BCPC_ASSERT_IMP(a_push_not_full, clock, reset, push |-> (count_ff != QCNT_W'(QUEUE_DEPTH)), "push into full queue")
   `BCPC_ASSERT_IMP(a_pop_not_empty, clock, reset, pop |-> (count_ff != '0), "pop from empty queue")
   `BCPC_ASSERT_NXT(a_count_up, clock, reset, (push && !pop), (count_ff == $past(count_ff) + 1'b1), "queue count did not advance")

endmodule

`default_nettype wire

@@ rtl/bcpc_back.sv @@
// ----------------------------------------------------------------------------
// bcpc_back
// Pipelined CPT kernels, parent mixing levels and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bayes_cpt_probability_combiner_macros.svh"

module bcpc_back
   import bcpc_pkg::*;
#(
   parameter int PERCENT_FULL = 100
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire work_type  work,
   input  wire qstat_type qstat,
   input  wire table_type tbl,
   output logic           pop,
   bcpc_rsp_if.source     rsp_if
);

   localparam int STAGES = 9;
   localparam pct_type FULL = pct_type'(PERCENT_FULL);

   localparam longint unsigned KDIV = longint'(PERCENT_FULL) * longint'(PERCENT_FULL);
   localparam int K_L     = $clog2(KDIV);
   localparam int K_SH    = KSUM_W + K_L;
   localparam int KPROD_W = 2 * KSUM_W + 1;
   localparam logic [KSUM_W:0] K_M = (KSUM_W + 1)'(((64'd1 << K_SH) + KDIV - 1) / KDIV);
   localparam logic [KSUM_W-1:0] KRND = KSUM_W'(KDIV / 2);

   localparam longint unsigned MDIV = longint'(PERCENT_FULL);
   localparam int M_L     = $clog2(MDIV);
   localparam int M_SH    = MSUM_W + M_L;
   localparam int MPROD_W = 2 * MSUM_W + 1;
   localparam logic [MSUM_W:0] M_M = (MSUM_W + 1)'(((64'd1 << M_SH) + MDIV - 1) / MDIV);

   typedef struct packed {
      pct_type     prob_c;
      pct_type     prob_d;
      pct_type     prob_e;
      parents_type parents;
      pct_type     k0;
      pct_type     l3;
      pct_type     l4;
   } side_type;

   logic                 adv;
   logic [STAGES-1:0]    stage_valid_ff, stage_valid_in;
   side_type             side_ff [STAGES];
   side_type             side_in [STAGES];

   logic [PAIR_W-1:0]    pp_ff [4];
   logic [PAIR_W-1:0]    pp_in [4];
   logic [KSUM_W-1:0]    ksum_ff [KERNELS];
   logic [KSUM_W-1:0]    ksum_in [KERNELS];
   logic [KPROD_W-1:0]   kprod_ff [KERNELS];
   logic [KPROD_W-1:0]   kprod_in [KERNELS];
   logic [MSUM_W-1:0]    msum3_ff [4];
   logic [MSUM_W-1:0]    msum3_in [4];
   logic [MPROD_W-1:0]   mprod3_ff [4];
   logic [MPROD_W-1:0]   mprod3_in [4];
   logic [MSUM_W-1:0]    msum4_ff [2];
   logic [MSUM_W-1:0]    msum4_in [2];
   logic [MPROD_W-1:0]   mprod4_ff [2];
   logic [MPROD_W-1:0]   mprod4_in [2];
   logic [MSUM_W-1:0]    msum5_ff, msum5_in;
   logic [MPROD_W-1:0]   mprod5_ff, mprod5_in;

   pct_type              kres [KERNELS];
   pct_type              l3 [4];
   pct_type              l4 [2];
   pct_type              l5;

   logic                 rsp_valid_ff, rsp_valid_in;
   pct_type              child_prob_ff, child_prob_in;

   assign adv               = !rsp_valid_ff || rsp_if.ready;
   assign pop               = adv && !qstat.empty;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.child_prob = child_prob_ff;

   // pair weights of parents A and B
   always_comb begin
      pct_type na;
      pct_type nb;
      na       = FULL - work.prob_a;
      nb       = FULL - work.prob_b;
      pp_in[0] = PAIR_W'(na) * PAIR_W'(nb);
      pp_in[1] = PAIR_W'(work.prob_a) * PAIR_W'(nb);
      pp_in[2] = PAIR_W'(na) * PAIR_W'(work.prob_b);
      pp_in[3] = PAIR_W'(work.prob_a) * PAIR_W'(work.prob_b);
   end

   // two-parent kernels
   always_comb begin
      for (int k = 0; k < KERNELS; k++) begin
         ksum_in[k] = KRND;
         for (int j = 0; j < 4; j++) begin
            ksum_in[k] = ksum_in[k] + KSUM_W'(pp_ff[j]) * KSUM_W'(tbl[4 * k + j]);
         end
         kprod_in[k] = KPROD_W'(ksum_ff[k]) * KPROD_W'(K_M);
         kres[k]     = clamp_pct(kprod_ff[k][K_SH +: KQ_W], FULL);
      end
   end

   // parent C, D and E mixing levels
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         msum3_in[j]  = mix_sum(kres[2 * j], kres[2 * j + 1], side_ff[2].prob_c, FULL);
         mprod3_in[j] = MPROD_W'(msum3_ff[j]) * MPROD_W'(M_M);
         l3[j]        = clamp_pct(PROB_W'(mprod3_ff[j][M_SH +: PCT_W]), FULL);
      end
      for (int i = 0; i < 2; i++) begin
         msum4_in[i]  = mix_sum(l3[2 * i], l3[2 * i + 1], side_ff[4].prob_d, FULL);
         mprod4_in[i] = MPROD_W'(msum4_ff[i]) * MPROD_W'(M_M);
         l4[i]        = clamp_pct(PROB_W'(mprod4_ff[i][M_SH +: PCT_W]), FULL);
      end
      msum5_in  = mix_sum(l4[0], l4[1], side_ff[6].prob_e, FULL);
      mprod5_in = MPROD_W'(msum5_ff) * MPROD_W'(M_M);
      l5        = clamp_pct(PROB_W'(mprod5_ff[M_SH +: PCT_W]), FULL);
   end

   always_comb begin
      side_in[0].prob_c  = work.prob_c;
      side_in[0].prob_d  = work.prob_d;
      side_in[0].prob_e  = work.prob_e;
      side_in[0].parents = work.parents;
      side_in[0].k0      = '0;
      side_in[0].l3      = '0;
      side_in[0].l4      = '0;
      for (int s = 1; s < STAGES; s++) begin
         side_in[s] = side_ff[s - 1];
      end
      side_in[3].k0 = kres[0];
      side_in[5].l3 = l3[0];
      side_in[7].l4 = l4[0];
      stage_valid_in = {stage_valid_ff[STAGES-2:0], !qstat.empty};
   end

   always_comb begin
      case (side_ff[STAGES-1].parents)
         PARENTS_2: child_prob_in = side_ff[STAGES-1].k0;
         PARENTS_3: child_prob_in = side_ff[STAGES-1].l3;
         PARENTS_4: child_prob_in = side_ff[STAGES-1].l4;
         default:   child_prob_in = l5;
      endcase
      rsp_valid_in = adv ? stage_valid_ff[STAGES-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            stage_valid_ff <= stage_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff     <= pp_in;
         ksum_ff   <= ksum_in;
         kprod_ff  <= kprod_in;
         msum3_ff  <= msum3_in;
         mprod3_ff <= mprod3_in;
         msum4_ff  <= msum4_in;
         mprod4_ff <= mprod4_in;
         msum5_ff  <= msum5_in;
         mprod5_ff <= mprod5_in;
         side_ff   <= side_in;
         child_prob_ff <= child_prob_in;
      end
   end

   `BCPC_ASSERT_IMP(a_child_in_range, clock, reset, rsp_valid_ff |-> (child_prob_ff <= FULL), "child probability above full scale")
   `BCPC_ASSERT_NXT(a_stall_holds_pipe, clock, reset, !adv, $stable(stage_valid_ff), "pipeline moved while stalled")
   `BCPC_ASSERT_NXT(a_pop_enters_pipe, clock, reset, pop, stage_valid_ff[0], "popped item lost at pipeline entry")

endmodule

`default_nettype wire

@@ rtl/bayes_cpt_probability_combiner.sv @@
// ----------------------------------------------------------------------------
// bayes_cpt_probability_combiner
// Path: front register, queue, nine-stage pipeline, response register.
// Throughput: one item per cycle if no stall, set by the multiply pipeline.
// Front register and a four-item queue decouple request from response stalls.
// Reset: synchronous; empties the pipeline, parent_count 5, table zero.
// ----------------------------------------------------------------------------
`default_nettype none

module bayes_cpt_probability_combiner
   import bcpc_pkg::*;
#(
   parameter int PERCENT_FULL  = 100,
   parameter int TABLE_ENTRIES = 32
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bcpc_req_if.sink   req_if,
   bcpc_rsp_if.source rsp_if,
   bcpc_csr_if.sink   csr_if
);

   logic [PCOUNT_W-1:0] parent_count_ff, parent_count_in;
   table_words_type     table_word_ff, table_word_in;
   table_type           table_raw;
   table_type           tbl;

   logic      push;
   logic      pop;
   work_type  front_work;
   work_type  queue_work;
   qstat_type qstat;

   assign csr_if.ready = 1'b1;
   assign table_raw    = table_word_ff;

   for (genvar k = 0; k < TABLE_MAX; k++) begin : g_entry
      if (k < TABLE_ENTRIES) begin : g_used
         assign tbl[k] = table_raw[k];
      end else begin : g_zero
         assign tbl[k] = '0;
      end
   end

   always_comb begin
      parent_count_in = parent_count_ff;
      table_word_in   = table_word_ff;
      if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            CSR_PARENT_COUNT: parent_count_in  = csr_if.data[PCOUNT_W-1:0];
            CSR_TABLE_0:      table_word_in[0] = csr_if.data;
            CSR_TABLE_1:      table_word_in[1] = csr_if.data;
            CSR_TABLE_2:      table_word_in[2] = csr_if.data;
            CSR_TABLE_3:      table_word_in[3] = csr_if.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parent_count_ff <= RESET_PARENT_COUNT;
         table_word_ff   <= '0;
      end else begin
         parent_count_ff <= parent_count_in;
         table_word_ff   <= table_word_in;
      end
   end

   bcpc_front #(
      .PERCENT_FULL (PERCENT_FULL)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .parent_count (parent_count_ff),
      .qstat        (qstat),
      .push         (push),
      .work         (front_work)
   );

   bcpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_work),
      .pop       (pop),
      .pop_data  (queue_work),
      .qstat     (qstat)
   );

   bcpc_back #(
      .PERCENT_FULL (PERCENT_FULL)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .work   (queue_work),
      .qstat  (qstat),
      .tbl    (tbl),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

`default_nettype wire

@@ test/bcpc_child_prob_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Child probability checker
// Watches the register, request and response channels of the combiner.
// Tracks parent_count and the table words, predicts child_prob for every
// accepted request and compares each response in order.
// ----------------------------------------------------------------------------

module bcpc_child_prob_checker
   import bcpc_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   bcpc_req_if       req_mon,
   bcpc_rsp_if       rsp_mon,
   bcpc_csr_if       csr_mon,
   output int        pending,
   output int        failures
);

   localparam int unsigned FULL = 100;

   logic [PCOUNT_W-1:0] pcount_reg;
   table_words_type     cpt_words;
   pct_type             expected_probs[$];
   pct_type             want;

   initial begin
      failures = 0;
      pending  = 0;
   end

   function automatic int unsigned sat_full(int unsigned v);
      return (v > FULL) ? FULL : v;
   endfunction

   function automatic int unsigned cpt_entry(table_words_type words, int unsigned idx);
      return int'(words[(idx & 31) >> 3][(idx & 7) * 8 +: ENTRY_W]);
   endfunction

   function automatic pct_type child_probability(logic [PCOUNT_W-1:0] pcount,
                                                 table_words_type words,
                                                 logic [PROB_W-1:0] a, logic [PROB_W-1:0] b,
                                                 logic [PROB_W-1:0] c, logic [PROB_W-1:0] d,
                                                 logic [PROB_W-1:0] e);
      int unsigned p[5];
      int unsigned r[8];
      int unsigned n, groups, q, s, na, nb, base;
      int          k, lvl;
      p[0] = sat_full(32'(a));
      p[1] = sat_full(32'(b));
      p[2] = sat_full(32'(c));
      p[3] = sat_full(32'(d));
      p[4] = sat_full(32'(e));
      n = 32'(pcount);
      if (n < 2) n = 2;
      if (n > 5) n = 5;
      groups = 1 << (n - 2);
      na = FULL - p[0];
      nb = FULL - p[1];
      for (k = 0; k < groups; k++) begin
         base = 4 * k;
         s = na * nb * cpt_entry(words, base) + p[0] * nb * cpt_entry(words, base + 1)
           + na * p[1] * cpt_entry(words, base + 2) + p[0] * p[1] * cpt_entry(words, base + 3);
         r[k] = sat_full((s + FULL * FULL / 2) / (FULL * FULL));
      end
      for (lvl = 3; lvl <= n; lvl++) begin
         q = p[lvl - 1];
         groups = groups >> 1;
         for (k = 0; k < groups; k++) begin
            r[k] = sat_full((r[2 * k] * (FULL - q) + r[2 * k + 1] * q + FULL / 2) / FULL);
         end
      end
      return pct_type'(r[0] & 'h7F);
   endfunction

   task automatic report(string what, int exp_val, int got_val);
      $display("%0t: %s: expected %0d, got %0d", $time, what, exp_val, got_val);
      failures++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pcount_reg = RESET_PARENT_COUNT;
         cpt_words  = '0;
         expected_probs.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_index_type'(csr_mon.index))
               CSR_PARENT_COUNT: pcount_reg = csr_mon.data[PCOUNT_W-1:0];
               CSR_TABLE_0: cpt_words[0] = csr_mon.data;
               CSR_TABLE_1: cpt_words[1] = csr_mon.data;
               CSR_TABLE_2: cpt_words[2] = csr_mon.data;
               CSR_TABLE_3: cpt_words[3] = csr_mon.data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_probs.size() == 0) begin
               report("child_prob with no item outstanding", -1, int'(rsp_mon.child_prob));
            end else begin
               want = expected_probs.pop_front();
               if (rsp_mon.child_prob !== want)
                  report("child_prob mismatch", int'(want), int'(rsp_mon.child_prob));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_probs.push_back(child_probability(pcount_reg, cpt_words,
               req_mon.prob_a, req_mon.prob_b, req_mon.prob_c, req_mon.prob_d,
               req_mon.prob_e));
         end
      end
      pending <= expected_probs.size();
   end

endmodule

@@ test/tb_bayes_cpt_probability_combiner.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bayes CPT probability combiner testbench
// Drives directed and random parent probability sets through several
// parent counts and table contents, with random idling on both channels.
// The checker beside the block predicts and compares every child_prob.
// ----------------------------------------------------------------------------

module tb_bayes_cpt_probability_combiner
   import bcpc_pkg::*;
();

   logic clock;
   logic reset;
   logic sink_ready = 1'b0;
   bit   calm;
   int   pending;
   int   failures;

   bcpc_req_if req();
   bcpc_rsp_if rsp();
   bcpc_csr_if csr();

   assign rsp.ready = sink_ready;

   bayes_cpt_probability_combiner dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   bcpc_child_prob_checker prob_check (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req),
      .rsp_mon  (rsp),
      .csr_mon  (csr),
      .pending  (pending),
      .failures (failures)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      sink_ready <= calm || ($urandom_range(99) >= 28);
   end

   function automatic logic [PROB_W-1:0] rand_prob();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd100;
         2: return 8'($urandom_range(255, 101));
         3: return 8'($urandom);
         default: return 8'($urandom_range(100));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] cpt_word(int unsigned style);
      logic [CSR_DATA_W-1:0] w;
      int                    i;
      w = {$urandom, $urandom};
      for (i = 0; i < 8; i++) begin
         case (style)
            1: w[8 * i +: 8] = 8'($urandom_range(100));
            2: w[8 * i +: 8] = 8'hFF;
            3: w[8 * i +: 8] = 8'h00;
            4: w[8 * i +: 8] = $urandom_range(1) ? 8'd100 : 8'd0;
            default: ;
         endcase
      end
      return w;
   endfunction

   task automatic send_item(logic [PROB_W-1:0] a, logic [PROB_W-1:0] b,
                            logic [PROB_W-1:0] c, logic [PROB_W-1:0] d,
                            logic [PROB_W-1:0] e);
      while (!calm && $urandom_range(99) < 28) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid  <= 1'b1;
      req.prob_a <= a;
      req.prob_b <= b;
      req.prob_c <= c;
      req.prob_d <= d;
      req.prob_e <= e;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic send_random();
      send_item(rand_prob(), rand_prob(), rand_prob(), rand_prob(), rand_prob());
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
   endtask

   task automatic configure(int unsigned pcount, int unsigned style);
      int w;
      drain();
      write_csr(CSR_PARENT_COUNT, {32'($urandom), 29'($urandom), 3'(pcount)});
      for (w = 0; w < TABLE_WORDS; w++)
         write_csr(CSR_INDEX_W'(CSR_TABLE_0) + CSR_INDEX_W'(w), cpt_word(style));
      // writes past the last table word must leave everything as it is
      write_csr(CSR_INDEX_W'(CSR_TABLE_3) + CSR_INDEX_W'($urandom_range(3, 1)),
                {$urandom, $urandom});
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned odd_counts[6];
      int          p, n, k;
      odd_counts = '{0, 1, 6, 7, 3, 4};
      reset      = 1'b1;
      calm       = 1'b0;
      req.valid  = 1'b0;
      req.prob_a = '0;
      req.prob_b = '0;
      req.prob_c = '0;
      req.prob_d = '0;
      req.prob_e = '0;
      csr.valid  = 1'b0;
      csr.index  = '0;
      csr.data   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_random();
      configure(5, 1);
      send_item(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      send_item(8'd100, 8'd100, 8'd100, 8'd100, 8'd100);
      send_item(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      send_item(8'd101, 8'd101, 8'd101, 8'd101, 8'd101);
      for (k = 0; k < 5; k++)
         send_item((k == 0) ? 8'd100 : 8'd0, (k == 1) ? 8'd100 : 8'd0,
                   (k == 2) ? 8'd100 : 8'd0, (k == 3) ? 8'd100 : 8'd0,
                   (k == 4) ? 8'd100 : 8'd0);
      configure(5, 2);
      send_item(8'd50, 8'd50, 8'd50, 8'd50, 8'd50);
      send_item(8'd100, 8'd100, 8'd100, 8'd100, 8'd100);
      configure(2, 0);
      send_item(8'd100, 8'd100, 8'd255, 8'd255, 8'd255);
      send_item(8'd0, 8'd100, 8'($urandom), 8'($urandom), 8'($urandom));
      for (k = 0; k < 6; k++) begin
         configure(odd_counts[k], k % 5);
         send_random();
      end

      for (p = 0; p < 8; p++) begin
         configure((p < 4) ? 2 + p : $urandom_range(7), p % 5);
         calm = (p == 3);
         for (n = 0; n < 204; n++) begin
            if (p == 5 && n == 102) drain();
            send_random();
         end
      end
      calm = 1'b0;

      drain();
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
